// File: rtl/fcp_pkg.sv
package fcp_pkg;

    // |arg| beyond this is treated as saturated sigmoid
    localparam int unsigned LIMIT_ARG = 50;

    // table coordinate |arg| in Q32, at most 50 * 2^32 when inside the limit
    localparam int X_W = 38;

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CUTOFF    = 2'd0,
        REG_SCALE     = 2'd1,
        REG_INV_WIDTH = 2'd2
    } fcp_reg_t;

    // per-word side data that rides along the pipeline
    typedef struct packed {
        logic        neg;
        logic        beyond;
        logic [63:0] p1;
    } fcp_side_t;

endpackage

// File: rtl/fcp_arg.sv
module fcp_arg #(
    parameter int FRAC_BITS = 16,
    parameter int SIGMOID_TABLE_DEPTH = 256,
    localparam int AW = fcp_pkg::X_W + $clog2(SIGMOID_TABLE_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [31:0]         wave_sq,
    input  logic [31:0]         cutoff,
    input  logic [31:0]         scale,
    input  logic [31:0]         inv_width,
    output logic                out_valid,
    output fcp_pkg::fcp_side_t  out_side,
    output logic [AW-1:0]       dividend
);
    import fcp_pkg::*;

    localparam int SH = 2 * FRAC_BITS + 1;
    localparam logic [64:0] LIMIT = 65'(LIMIT_ARG) << SH;

    logic [32:0] two_cut;
    logic [32:0] mag_next;
    logic        neg_next;
    logic [63:0] p1_next;
    logic [64:0] am_next;
    logic [96:0] am_ext;
    logic [X_W-1:0] x_next;
    logic        beyond_next;
    logic [AW-1:0] a_next;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [32:0] mag1_reg;
    logic [64:0] am2_reg;
    logic [X_W-1:0] x3_reg;
    logic [AW-1:0]  a4_reg;
    fcp_side_t   side1_reg, side2_reg, side3_reg, side4_reg;

    always_comb
    begin
        two_cut  = {cutoff, 1'b0};
        neg_next = {1'b0, wave_sq} < two_cut;
        mag_next = neg_next ? two_cut - {1'b0, wave_sq} : {1'b0, wave_sq} - two_cut;
        p1_next  = 64'(wave_sq) * 64'(scale);
    end

    // |arg| in Q(2F+1); anything past 2^64 is past the limit as well
    assign am_next = 65'(mag1_reg) * 65'(inv_width);

    always_comb
    begin
        am_ext      = {am2_reg, 32'b0};
        x_next      = X_W'(am_ext >> SH);
        beyond_next = am2_reg > LIMIT;
    end

    assign a_next = AW'(x3_reg) * AW'(SIGMOID_TABLE_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag1_reg         <= mag_next;
        side1_reg.neg    <= neg_next;
        side1_reg.beyond <= 1'b0;
        side1_reg.p1     <= p1_next;

        am2_reg   <= am_next;
        side2_reg <= side1_reg;

        x3_reg           <= x_next;
        side3_reg.neg    <= side2_reg.neg;
        side3_reg.beyond <= beyond_next;
        side3_reg.p1     <= side2_reg.p1;

        a4_reg    <= a_next;
        side4_reg <= side3_reg;
    end

    assign out_valid = v4_reg;
    assign out_side  = side4_reg;
    assign dividend  = a4_reg;

endmodule

// File: rtl/fcp_div50.sv
module fcp_div50 #(
    parameter int SIGMOID_TABLE_DEPTH = 256,
    localparam int AW = fcp_pkg::X_W + $clog2(SIGMOID_TABLE_DEPTH + 1),
    localparam int QW = 32 + $clog2(SIGMOID_TABLE_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  fcp_pkg::fcp_side_t  in_side,
    input  logic [AW-1:0]       dividend,
    output logic                out_valid,
    output fcp_pkg::fcp_side_t  out_side,
    output logic [QW-1:0]       quotient
);
    import fcp_pkg::*;

    // floor(a/50) = (a * ceil(2^S/50)) >> S with S = AW + 6, exact for every a below 2^AW
    localparam int SHIFT = AW + $clog2(LIMIT_ARG);
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(LIMIT_ARG) - 64'd1) / 64'(LIMIT_ARG);

    logic [63:0]   a_ext;
    logic [63:0]   ll_next, lh_next, hl_next, hh_next;
    logic [64:0]   mid_next;
    logic [127:0]  prod_next;
    logic [QW-1:0] q_next;

    logic          v1_reg, v2_reg;
    logic [63:0]   ll1_reg, lh1_reg, hl1_reg, hh1_reg;
    logic [QW-1:0] q2_reg;
    fcp_side_t     side1_reg, side2_reg;

    // D1: 32x32 partial products against the reciprocal
    always_comb
    begin
        a_ext   = 64'(dividend);
        ll_next = 64'(a_ext[31:0]) * 64'(RECIP[31:0]);
        lh_next = 64'(a_ext[31:0]) * 64'(RECIP[63:32]);
        hl_next = 64'(a_ext[63:32]) * 64'(RECIP[31:0]);
        hh_next = 64'(a_ext[63:32]) * 64'(RECIP[63:32]);
    end

    // D2: low and high products do not overlap, only the middle pair is added in
    always_comb
    begin
        mid_next  = 65'(lh1_reg) + 65'(hl1_reg);
        prod_next = {hh1_reg, ll1_reg} + {31'b0, mid_next, 32'b0};
        q_next    = QW'(prod_next >> SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ll1_reg   <= ll_next;
        lh1_reg   <= lh_next;
        hl1_reg   <= hl_next;
        hh1_reg   <= hh_next;
        side1_reg <= in_side;

        q2_reg    <= q_next;
        side2_reg <= side1_reg;
    end

    assign out_valid = v2_reg;
    assign out_side  = side2_reg;
    assign quotient  = q2_reg;

endmodule

// File: rtl/fcp_sigmoid.sv
module fcp_sigmoid #(
    parameter int SIGMOID_TABLE_DEPTH = 256,
    localparam int QW = 32 + $clog2(SIGMOID_TABLE_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  fcp_pkg::fcp_side_t  in_side,
    input  logic [QW-1:0]       pos,
    output logic                out_valid,
    output fcp_pkg::fcp_side_t  out_side,
    output logic [32:0]         fp,
    output logic [32:0]         fm
);
    import fcp_pkg::*;

    localparam int IW = $clog2(SIGMOID_TABLE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SIGMOID_TABLE_DEPTH);
    localparam logic [63:0] STEP_H = (64'(LIMIT_ARG) << 32) / 64'(SIGMOID_TABLE_DEPTH);

    typedef logic [31:0] rom_t [0:SIGMOID_TABLE_DEPTH];

    function automatic logic [63:0] mulq32(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[95:32];
    endfunction

    // shift-subtract quotient, only used while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], n[i]};
            if (r >= 65'(d))
            begin
                r    = r - 65'(d);
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // entry i = 1/(1+e^(i*h)) in Q32, h = 50/depth; e^h from a 41-term series
    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        logic [63:0] e;
        term = 64'(ONE_Q32);
        sum  = 64'(ONE_Q32);
        e    = 64'(ONE_Q32);
        for (int k = 1; k <= 40; k++)
        begin
            term = udiv64(mulq32(term, STEP_H), 64'(k));
            sum  = sum + term;
        end
        r = udiv64({64{1'b1}}, sum);
        rom[0] = 32'h8000_0000;
        for (int i = 1; i <= SIGMOID_TABLE_DEPTH; i++)
        begin
            e      = mulq32(e, r);
            rom[i] = 32'(udiv64(e << 32, 64'(ONE_Q32) + e));
        end
        return rom;
    endfunction

    localparam rom_t SIG_ROM = build_rom();

    logic [IW-1:0] idx;
    logic          over;
    logic [IW-1:0] idx_a;
    logic [IW-1:0] idx_b;
    logic [31:0]   r0_next;
    logic [31:0]   d_next;
    logic [63:0]   prod_next;
    logic [31:0]   s;
    logic [32:0]   fp_next;
    logic [32:0]   fm_next;

    logic          v1_reg, v2_reg, v3_reg;
    logic [31:0]   r0_1_reg, d1_reg, fr1_reg;
    logic [31:0]   r0_2_reg, dfr2_reg;
    logic [32:0]   fp3_reg, fm3_reg;
    fcp_side_t     side1_reg, side2_reg, side3_reg;

    always_comb
    begin
        idx     = pos[QW-1:32];
        over    = idx >= LAST_IDX;
        idx_a   = over ? LAST_IDX : idx;
        idx_b   = over ? LAST_IDX : IW'(idx + 1'b1);
        r0_next = SIG_ROM[idx_a];
        d_next  = r0_next - SIG_ROM[idx_b];
    end

    assign prod_next = 64'(d1_reg) * 64'(fr1_reg);

    always_comb
    begin
        s = r0_2_reg - dfr2_reg;
        if (side2_reg.beyond)
        begin
            fp_next = side2_reg.neg ? ONE_Q32 : '0;
            fm_next = side2_reg.neg ? '0 : ONE_Q32;
        end
        else
        begin
            fp_next = side2_reg.neg ? ONE_Q32 - 33'(s) : 33'(s);
            fm_next = side2_reg.neg ? 33'(s) : ONE_Q32 - 33'(s);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_1_reg  <= r0_next;
        d1_reg    <= d_next;
        fr1_reg   <= pos[31:0];
        side1_reg <= in_side;

        r0_2_reg  <= r0_1_reg;
        dfr2_reg  <= prod_next[63:32];
        side2_reg <= side1_reg;

        fp3_reg   <= fp_next;
        fm3_reg   <= fm_next;
        side3_reg <= side2_reg;
    end

    assign out_valid = v3_reg;
    assign out_side  = side3_reg;
    assign fp        = fp3_reg;
    assign fm        = fm3_reg;

endmodule

// File: rtl/fcp_terms.sv
module fcp_terms #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  fcp_pkg::fcp_side_t  in_side,
    input  logic [32:0]         fp,
    input  logic [32:0]         fm,
    input  logic [31:0]         scale,
    input  logic [31:0]         inv_width,
    output logic                done,
    output logic [31:0]         potential_term,
    output logic [31:0]         derivative_term,
    output logic                saturated
);
    import fcp_pkg::*;

    // fm and fp are at most 1.0, so bit 32 set means the low word is zero
    // and the product is just the other operand shifted up.

    logic [63:0] pl_next, ph_next, ap_next;
    logic [95:0] full_next;
    logic [31:0] pot_next;
    logic        pov_next;
    logic [63:0] m1_next;
    logic [32:0] at_next;
    logic [63:0] ql_next, qh_next;
    logic [95:0] sum_q;
    logic [63:0] m2_next;
    logic [63:0] rl_next, rh_next;
    logic [95:0] prod_next;
    logic [31:0] bt_next;
    logic        bto_next;
    logic [33:0] der_sum;
    logic        der_sat;

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, done_reg;
    logic [63:0] pl1_reg, ph1_reg, ap1_reg, p1_1_reg;
    logic        fmt1_reg;
    logic [32:0] fp1_reg, fp2_reg;
    logic [31:0] pot2_reg, pot3_reg, pot4_reg, pot5_reg, pot6_reg;
    logic        pov2_reg, pov3_reg, pov4_reg, pov5_reg, pov6_reg;
    logic [32:0] at2_reg, at3_reg, at4_reg, at5_reg, at6_reg;
    logic [63:0] m1_2_reg, m1_3_reg;
    logic [63:0] ql3_reg, qh3_reg;
    logic        fpt3_reg;
    logic [63:0] m2_4_reg;
    logic [63:0] rl5_reg, rh5_reg;
    logic [31:0] bt6_reg;
    logic        bto6_reg;
    logic [31:0] pot_out_reg, der_out_reg;
    logic        sat_out_reg;

    // T1: partial products of p1*fm and facs*fm
    always_comb
    begin
        pl_next = 64'(in_side.p1[31:0]) * 64'(fm[31:0]);
        ph_next = 64'(in_side.p1[63:32]) * 64'(fm[31:0]);
        ap_next = 64'(scale) * 64'(fm[31:0]);
    end

    // T2: full p1*fm, potential term and 2*facs*fm
    always_comb
    begin
        full_next = fmt1_reg ? {p1_1_reg, 32'b0} : 96'(pl1_reg) + {ph1_reg, 32'b0};
        pov_next  = |(full_next >> (64 + FRAC_BITS));
        pot_next  = full_next[32 + FRAC_BITS +: 32];
        m1_next   = full_next[95:32];
        at_next   = fmt1_reg ? {scale, 1'b0} : ap1_reg[63:31];
    end

    // T3/T4: m2 = (m1*fp) >> 32
    always_comb
    begin
        ql_next = 64'(m1_2_reg[31:0]) * 64'(fp2_reg[31:0]);
        qh_next = 64'(m1_2_reg[63:32]) * 64'(fp2_reg[31:0]);
        sum_q   = 96'(ql3_reg) + {qh3_reg, 32'b0};
        m2_next = fpt3_reg ? m1_3_reg : sum_q[95:32];
    end

    // T5/T6: m2 * inverse_width rescaled by 2F
    always_comb
    begin
        rl_next   = 64'(m2_4_reg[31:0]) * 64'(inv_width);
        rh_next   = 64'(m2_4_reg[63:32]) * 64'(inv_width);
        prod_next = 96'(rl5_reg) + {rh5_reg, 32'b0};
        bto_next  = |(prod_next >> (32 + 2 * FRAC_BITS));
        bt_next   = prod_next[2 * FRAC_BITS +: 32];
    end

    // T7: final sum and clipping
    always_comb
    begin
        der_sum = 34'(at6_reg) + 34'(bt6_reg);
        der_sat = bto6_reg | (|der_sum[33:32]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            done_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pl1_reg  <= pl_next;
        ph1_reg  <= ph_next;
        ap1_reg  <= ap_next;
        p1_1_reg <= in_side.p1;
        fmt1_reg <= fm[32];
        fp1_reg  <= fp;

        pot2_reg <= pot_next;
        pov2_reg <= pov_next;
        m1_2_reg <= m1_next;
        at2_reg  <= at_next;
        fp2_reg  <= fp1_reg;

        ql3_reg  <= ql_next;
        qh3_reg  <= qh_next;
        fpt3_reg <= fp2_reg[32];
        m1_3_reg <= m1_2_reg;
        pot3_reg <= pot2_reg;
        pov3_reg <= pov2_reg;
        at3_reg  <= at2_reg;

        m2_4_reg <= m2_next;
        pot4_reg <= pot3_reg;
        pov4_reg <= pov3_reg;
        at4_reg  <= at3_reg;

        rl5_reg  <= rl_next;
        rh5_reg  <= rh_next;
        pot5_reg <= pot4_reg;
        pov5_reg <= pov4_reg;
        at5_reg  <= at4_reg;

        bt6_reg  <= bt_next;
        bto6_reg <= bto_next;
        pot6_reg <= pot5_reg;
        pov6_reg <= pov5_reg;
        at6_reg  <= at5_reg;

        pot_out_reg <= pov6_reg ? '1 : pot6_reg;
        der_out_reg <= der_sat ? '1 : der_sum[31:0];
        sat_out_reg <= pov6_reg | der_sat;
    end

    assign done            = done_reg;
    assign potential_term  = pot_out_reg;
    assign derivative_term = der_out_reg;
    assign saturated       = sat_out_reg;

endmodule

// File: rtl/fermi_confinement_potential.sv
// Smoothed confinement potential. Takes one wave_sq word per clock (busy stays low) and
// returns potential_term, derivative_term and saturated with a one-cycle done strobe,
// in the order the words came in. The pipeline first forms the table coordinate, then
// divides by 50 with a reciprocal multiply to give the table position, then does the
// sigmoid lookup and interpolation, and last forms the output products.
// The result cannot be held off: capture it in the cycle done is high. Write
// cutoff_energy, scale_factor and inverse_width (Q16.16 by default) only while no words
// are in flight.
module fermi_confinement_potential #(
    parameter int FRAC_BITS = 16,
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [31:0]                   wave_sq,
    input  logic                          cfg_write,
    input  logic [fcp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output logic                          done,
    output logic [31:0]                   potential_term,
    output logic [31:0]                   derivative_term,
    output logic                          saturated
);
    import fcp_pkg::*;

    localparam int AW = X_W + $clog2(SIGMOID_TABLE_DEPTH + 1);
    localparam int QW = 32 + $clog2(SIGMOID_TABLE_DEPTH + 1);

    logic [31:0] cutoff_reg, scale_reg, inv_width_reg;
    logic [31:0] cutoff_next, scale_next, inv_width_next;

    logic          arg_valid, div_valid, sig_valid;
    fcp_side_t     arg_side, div_side, sig_side;
    logic [AW-1:0] dividend;
    logic [QW-1:0] pos;
    logic [32:0]   fp, fm;

    always_comb
    begin
        cutoff_next    = cutoff_reg;
        scale_next     = scale_reg;
        inv_width_next = inv_width_reg;
        if (cfg_write)
        begin
            case (fcp_reg_t'(cfg_index))
                REG_CUTOFF:    cutoff_next    = cfg_data;
                REG_SCALE:     scale_next     = cfg_data;
                REG_INV_WIDTH: inv_width_next = cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg    <= '0;
            scale_reg     <= '0;
            inv_width_reg <= 32'(1) << FRAC_BITS;
        end
        else
        begin
            cutoff_reg    <= cutoff_next;
            scale_reg     <= scale_next;
            inv_width_reg <= inv_width_next;
        end
    end

    // fully pipelined, a word can enter every cycle
    assign busy = 1'b0;

    fcp_arg #(
        .FRAC_BITS           (FRAC_BITS),
        .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_arg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .wave_sq   (wave_sq),
        .cutoff    (cutoff_reg),
        .scale     (scale_reg),
        .inv_width (inv_width_reg),
        .out_valid (arg_valid),
        .out_side  (arg_side),
        .dividend  (dividend)
    );

    fcp_div50 #(
        .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_div50 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (arg_valid),
        .in_side   (arg_side),
        .dividend  (dividend),
        .out_valid (div_valid),
        .out_side  (div_side),
        .quotient  (pos)
    );

    fcp_sigmoid #(
        .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_sigmoid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_side   (div_side),
        .pos       (pos),
        .out_valid (sig_valid),
        .out_side  (sig_side),
        .fp        (fp),
        .fm        (fm)
    );

    fcp_terms #(
        .FRAC_BITS (FRAC_BITS)
    ) u_terms (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (sig_valid),
        .in_side         (sig_side),
        .fp              (fp),
        .fm              (fm),
        .scale           (scale_reg),
        .inv_width       (inv_width_reg),
        .done            (done),
        .potential_term  (potential_term),
        .derivative_term (derivative_term),
        .saturated       (saturated)
    );

endmodule
